### rtl/signed_fraction_to_binary_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef SIGNED_FRACTION_TO_BINARY_MACROS_SVH
`define SIGNED_FRACTION_TO_BINARY_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset
`define SFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent may carry its own constant delay
`define SFB_ASSERT_SEQ(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

`endif

### rtl/sfb_pkg.sv
// Types, constants and helper functions for the signed fraction divider.
package sfb_pkg;

    localparam int DATA_W = 32;   // operand and quotient width
    localparam int MAG_W  = 31;   // magnitude after range reduction, up to 2^30
    localparam int REM_W  = 30;   // partial remainder, always below the divisor
    localparam int QUO_W  = 31;   // quotient magnitude bits 30..0

    localparam logic signed [DATA_W-1:0] HALF_RANGE = 32'sh4000_0000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    // Payload carried from stage to stage
    typedef struct packed {
        t_status            status;
        logic               neg;
        logic [REM_W-1:0]   rem;
        logic [MAG_W-1:0]   div;
        logic [QUO_W-1:0]   quo;
    } t_stage;

    function automatic logic in_half_range(input logic signed [DATA_W-1:0] v);
        return (v >= -HALF_RANGE) && (v < HALF_RANGE);
    endfunction

    // Divide by two, truncating toward zero
    function automatic logic signed [DATA_W-1:0] halve(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W:0] t;
        t = {v[DATA_W-1], v} + {{DATA_W{1'b0}}, v[DATA_W-1]};
        return t[DATA_W:1];
    endfunction

    // Magnitude of an already reduced operand (at most 2^30)
    function automatic logic [MAG_W-1:0] magnitude(input logic signed [DATA_W-1:0] v);
        logic [DATA_W-1:0] a;
        a = v[DATA_W-1] ? (~v + {{(DATA_W-1){1'b0}}, 1'b1}) : v;
        return a[MAG_W-1:0];
    endfunction

endpackage

### rtl/sfb_prep.sv
// Input stage: range reduction, magnitudes, sign and special-case flags.
module sfb_prep (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [sfb_pkg::DATA_W-1:0]   i_numerator,
    input  logic signed [sfb_pkg::DATA_W-1:0]   i_denominator,
    output logic                                o_valid,
    output sfb_pkg::t_stage                     o_stage
);
    import sfb_pkg::*;

    logic                       both_in;
    logic signed [DATA_W-1:0]   red_num;
    logic signed [DATA_W-1:0]   red_den;
    logic [MAG_W-1:0]           mag_num;
    logic [MAG_W-1:0]           mag_den;
    logic                       r_valid;
    t_stage                     n_stage;
    t_stage                     r_stage;

    // Halve both operands when either is outside the half range
    always_comb begin
        both_in = in_half_range(i_numerator) && in_half_range(i_denominator);
        red_num = both_in ? i_numerator   : halve(i_numerator);
        red_den = both_in ? i_denominator : halve(i_denominator);
        mag_num = magnitude(red_num);
        mag_den = magnitude(red_den);
    end

    // Flags: zero divisor wins over out of range
    always_comb begin
        n_stage.neg = red_num[DATA_W-1] ^ red_den[DATA_W-1];
        n_stage.rem = mag_num[REM_W-1:0];
        n_stage.div = mag_den;
        n_stage.quo = '0;
        if (mag_den == '0) begin
            n_stage.status = ST_DIV_ZERO;
        end else if (mag_num >= mag_den) begin
            n_stage.status = ST_RANGE;
        end else begin
            n_stage.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

### rtl/sfb_div_step.sv
// One restoring division step: double, compare, subtract, shift in a quotient bit.
module sfb_div_step (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  sfb_pkg::t_stage i_stage,
    output logic            o_valid,
    output sfb_pkg::t_stage o_stage
);
    import sfb_pkg::*;

    logic [MAG_W-1:0]   dbl;
    logic               ge;
    logic [MAG_W-1:0]   diff;
    logic               r_valid;
    t_stage             n_stage;
    t_stage             r_stage;

    // Doubled remainder stays below 2^31, so the compare is 31 bits wide
    always_comb begin
        dbl     = {i_stage.rem, 1'b0};
        ge      = (dbl >= i_stage.div);
        diff    = ge ? (dbl - i_stage.div) : dbl;
        n_stage = i_stage;
        n_stage.rem = diff[REM_W-1:0];
        n_stage.quo = {i_stage.quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

### rtl/sfb_out.sv
// Output stage: align the quotient, apply the sign, zero it for flagged items.
module sfb_out #(
    parameter int FRACTION_BITS = 31
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  sfb_pkg::t_stage                     i_stage,
    output logic                                o_done,
    output logic signed [sfb_pkg::DATA_W-1:0]   o_quotient,
    output sfb_pkg::t_status                    o_status
);
    import sfb_pkg::*;

    localparam int SHIFT = QUO_W - FRACTION_BITS;

    logic [QUO_W-1:0]   aligned;
    logic [DATA_W-1:0]  mag;
    logic [DATA_W-1:0]  n_quotient;
    logic               r_done;
    logic [DATA_W-1:0]  r_quotient;
    t_status            r_status;

    // Bits below position 31 - FRACTION_BITS stay zero
    always_comb begin
        aligned = i_stage.quo << SHIFT;
        mag     = {1'b0, aligned};
        if (i_stage.status != ST_OK) begin
            n_quotient = '0;
        end else if (i_stage.neg) begin
            n_quotient = ~mag + {{(DATA_W-1){1'b0}}, 1'b1};
        end else begin
            n_quotient = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quotient <= n_quotient;
        r_status   <= i_stage.status;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quotient;
    assign o_status   = r_status;

endmodule

### rtl/signed_fraction_to_binary.sv
// Top level of the pipelined signed fraction to Q0.31 divider.
//
// Usage:
//   Command channel: an operand pair (i_numerator, i_denominator) transfers at
//   a rising edge with start high and busy low. busy is held low, so a new
//   pair may transfer on every clock.
//   Result channel: o_quotient and o_status are valid for one cycle while
//   o_done is high; they transfer at the edge that ends that cycle.
//   Pipeline: one input stage, one division stage per quotient bit and one
//   output stage, each registered, between the command transfer and o_done.
//   Throughput: one item per cycle; each division stage holds one 31-bit
//   compare and subtract, which sets the clock period.
//   Results come out in command order.
//   Status: ST_OK, ST_DIV_ZERO (divisor zero after halving) or ST_RANGE
//   (numerator magnitude not below divisor); quotient is zero when not ok.
//   Reset (synchronous, active low) clears every stage valid bit, so items
//   in flight are dropped and o_done is low after reset.
//   The receiver cannot stall; results must be taken when o_done is high.
module signed_fraction_to_binary #(
    parameter int FRACTION_BITS = 31
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sfb_pkg::DATA_W-1:0]   i_numerator,
    input  logic signed [sfb_pkg::DATA_W-1:0]   i_denominator,
    output logic                                o_done,
    output logic signed [sfb_pkg::DATA_W-1:0]   o_quotient,
    output sfb_pkg::t_status                    o_status
);
    import sfb_pkg::*;

    logic   accept;
    logic   w_valid [0:FRACTION_BITS];
    t_stage w_stage [0:FRACTION_BITS];

    // Fully pipelined, so commands are always taken
    assign busy   = 1'b0;
    assign accept = start && !busy;

    sfb_prep u_prep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (accept),
        .i_numerator   (i_numerator),
        .i_denominator (i_denominator),
        .o_valid       (w_valid[0]),
        .o_stage       (w_stage[0])
    );

    // One registered division step per quotient bit
    for (genvar g = 0; g < FRACTION_BITS; g++) begin : g_step
        sfb_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_stage (w_stage[g]),
            .o_valid (w_valid[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    sfb_out #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[FRACTION_BITS]),
        .i_stage    (w_stage[FRACTION_BITS]),
        .o_done     (o_done),
        .o_quotient (o_quotient),
        .o_status   (o_status)
    );

endmodule

### rtl/sfb_checker.sv
// Port-level checker for the signed fraction divider, with its bind.
`include "signed_fraction_to_binary_macros.svh"

module sfb_checker #(
    parameter int FRACTION_BITS = 31
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 o_done,
    input logic signed [sfb_pkg::DATA_W-1:0]    o_quotient,
    input sfb_pkg::t_status                     o_status
);
    import sfb_pkg::*;

    localparam int LATENCY = FRACTION_BITS + 2;

    // The pipeline never refuses a command
    `SFB_ASSERT_NOW(a_never_busy, i_clk, i_rst_n, 1'b1, !busy, "busy raised")

    // Every command transfer yields a result after the fixed latency
    `SFB_ASSERT_SEQ(a_latency, i_clk, i_rst_n,
                    start && !busy, ##LATENCY o_done, "result missing")

    // Flagged results carry a zero quotient
    `SFB_ASSERT_NOW(a_flag_zero, i_clk, i_rst_n,
                    o_done && (o_status != ST_OK), o_quotient == '0,
                    "flagged quotient not zero")

    // A proper fraction never reaches minus one
    `SFB_ASSERT_NOW(a_quo_range, i_clk, i_rst_n,
                    o_done && (o_status == ST_OK), o_quotient != 32'sh8000_0000,
                    "quotient out of range")

endmodule

bind signed_fraction_to_binary sfb_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_sfb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_done     (o_done),
    .o_quotient (o_quotient),
    .o_status   (o_status)
);

### tb/sv/signed_fraction_to_binary_test.sv
// Self-checking testbench for the pipelined signed fraction to Q0.31 divider.
`timescale 1ns / 100ps

module signed_fraction_to_binary_test;
    import sfb_pkg::*;

    localparam int FRAC_BITS    = 31;
    localparam int LATENCY      = FRAC_BITS + 2;
    localparam int STALL_LIMIT  = 500;
    localparam int PHASE_ITEMS  = 270;
    localparam int N_DIRECTED   = 22;

    localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] HALF_POS = 32'sh4000_0000;
    localparam logic signed [31:0] HALF_NEG = 32'shC000_0000;
    localparam longint HALF_SPAN = 64'sd1073741824;

    // One quotient with its status
    typedef struct packed {
        logic signed [31:0] quotient;
        t_status            status;
    } frac_result_t;

    // Directed row: operands, and a typed-in result where it is obvious
    typedef struct packed {
        logic signed [31:0] num;
        logic signed [31:0] den;
        logic               typed;
        logic signed [31:0] quotient;
        t_status            status;
    } stim_row_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_numerator;
    logic signed [31:0] i_denominator;
    logic               o_done;
    logic signed [31:0] o_quotient;
    t_status            o_status;

    frac_result_t owed_quotients[$];
    int           error_count;
    int           items_sent;
    int           quotients_checked;
    int           ok_seen;
    int           negative_seen;
    int           div_zero_seen;
    int           range_seen;
    int           stall_cycles;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{32'sd0,        32'sd0,        1'b1, 32'sd0,          ST_DIV_ZERO},
        '{32'sd7,        32'sd0,        1'b1, 32'sd0,          ST_DIV_ZERO},
        '{MOST_NEG,      32'sd1,        1'b1, 32'sd0,          ST_DIV_ZERO},
        '{MOST_POS,      -32'sd1,       1'b1, 32'sd0,          ST_DIV_ZERO},
        '{32'sd5,        32'sd5,        1'b1, 32'sd0,          ST_RANGE},
        '{-32'sd9,       32'sd4,        1'b1, 32'sd0,          ST_RANGE},
        '{MOST_NEG,      MOST_NEG,      1'b1, 32'sd0,          ST_RANGE},
        '{32'sd0,        -32'sd3,       1'b1, 32'sd0,          ST_OK},
        '{32'sd1,        32'sd2,        1'b1, 32'sh4000_0000,  ST_OK},
        '{-32'sd1,       32'sd2,        1'b1, 32'shC000_0000,  ST_OK},
        '{32'sd3,        -32'sd4,       1'b1, 32'shA000_0000,  ST_OK},
        '{MOST_POS,      MOST_NEG,      1'b0, 32'sd0,          ST_OK},
        '{MOST_NEG,      MOST_POS,      1'b0, 32'sd0,          ST_OK},
        '{32'sd1,        32'sd3,        1'b0, 32'sd0,          ST_OK},
        '{-32'sd1,       -32'sd3,       1'b0, 32'sd0,          ST_OK},
        '{32'sd1,        HALF_NEG,      1'b0, 32'sd0,          ST_OK},
        '{32'sh3FFF_FFFF, HALF_NEG,     1'b0, 32'sd0,          ST_OK},
        '{HALF_NEG,      HALF_POS,      1'b0, 32'sd0,          ST_OK},
        '{32'sh5555_5555, MOST_POS,     1'b0, 32'sd0,          ST_OK},
        '{-32'sd12345,   32'sd67890,    1'b0, 32'sd0,          ST_OK},
        '{32'sd0,        MOST_NEG,      1'b0, 32'sd0,          ST_OK},
        '{32'shFFFF_FFFE, 32'sh8000_0001, 1'b0, 32'sd0,        ST_OK}
    };

    signed_fraction_to_binary #(
        .FRACTION_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_numerator   (i_numerator),
        .i_denominator (i_denominator),
        .o_done        (o_done),
        .o_quotient    (o_quotient),
        .o_status      (o_status)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = ~i_clk;
    end

    // Range reduction, then restoring division of the magnitudes
    function automatic frac_result_t divide_fraction(input logic signed [31:0] num,
                                                     input logic signed [31:0] den);
        longint       n;
        longint       d;
        longint       mag_n;
        longint       mag_d;
        longint       rem;
        logic [31:0]  q;
        int           bit_idx;
        frac_result_t res;
        n = num;
        d = den;
        if (!(n >= -HALF_SPAN && n < HALF_SPAN && d >= -HALF_SPAN && d < HALF_SPAN)) begin
            n = n / 2;
            d = d / 2;
        end
        res.quotient = '0;
        if (d == 0) begin
            res.status = ST_DIV_ZERO;
        end else begin
            mag_n = (n < 0) ? -n : n;
            mag_d = (d < 0) ? -d : d;
            if (mag_n >= mag_d) begin
                res.status = ST_RANGE;
            end else begin
                rem = mag_n;
                q   = '0;
                for (bit_idx = 0; bit_idx < FRAC_BITS && bit_idx < 31; bit_idx++) begin
                    rem = rem << 1;
                    if (rem >= mag_d) begin
                        q[30 - bit_idx] = 1'b1;
                        rem = rem - mag_d;
                    end
                end
                if ((n < 0) != (d < 0))
                    q = -q;
                res.quotient = q;
                res.status   = ST_OK;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    // Present one operand pair, hold it until it transfers, then maybe idle
    task automatic issue_division(input logic signed [31:0] num,
                                  input logic signed [31:0] den,
                                  input int idle_pct,
                                  input logic typed,
                                  input frac_result_t typed_res);
        start         <= 1'b1;
        i_numerator   <= num;
        i_denominator <= den;
        do @(posedge i_clk); while (!(start === 1'b1 && busy === 1'b0));
        owed_quotients.push_back(typed ? typed_res : divide_fraction(num, den));
        items_sent++;
        // Each cycle is idle with the given chance
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every owed quotient has come back
    task automatic drain_pipeline();
        start <= 1'b0;
        do @(posedge i_clk); while (owed_quotients.size() != 0);
    endtask

    // Result checker and watchdog
    always @(posedge i_clk) begin
        frac_result_t exp_res;
        if (i_rst_n === 1'b1 && $isunknown(o_done))
            report_mismatch("o_done unknown");
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (owed_quotients.size() == 0) begin
                report_mismatch($sformatf("unexpected result q=%h st=%0d",
                                          o_quotient, o_status));
            end else begin
                exp_res = owed_quotients.pop_front();
                quotients_checked++;
                case (exp_res.status)
                    ST_OK: begin
                        ok_seen++;
                        if (exp_res.quotient < 0)
                            negative_seen++;
                    end
                    ST_DIV_ZERO: div_zero_seen++;
                    default:     range_seen++;
                endcase
                if (o_quotient !== exp_res.quotient)
                    report_mismatch($sformatf("quotient %h, expected %h",
                                              o_quotient, exp_res.quotient));
                if (o_status !== exp_res.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, exp_res.status));
            end
        end
        if (o_done === 1'b1 || (start === 1'b1 && busy === 1'b0))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("[signed_fraction_to_binary] ERROR");
            $finish;
        end
    end

    // Stimulus
    initial begin : stimulus
        logic signed [31:0] num;
        logic signed [31:0] den;
        logic signed [31:0] tmp;
        longint             mag_n;
        longint             mag_d;
        frac_result_t       typed_res;
        int                 idle_pct;
        int                 kind;
        logic signed [31:0] edge_vals [9];

        edge_vals = '{MOST_NEG, MOST_POS, HALF_POS, HALF_NEG, 32'sh3FFF_FFFF,
                      32'shBFFF_FFFF, 32'sd0, 32'sd1, -32'sd1};
        error_count       = 0;
        items_sent        = 0;
        quotients_checked = 0;
        ok_seen           = 0;
        negative_seen     = 0;
        div_zero_seen     = 0;
        range_seen        = 0;
        stall_cycles      = 0;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_numerator   <= '0;
        i_denominator <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed table, back to back
        foreach (directed_rows[r]) begin
            typed_res.quotient = directed_rows[r].quotient;
            typed_res.status   = directed_rows[r].status;
            issue_division(directed_rows[r].num, directed_rows[r].den, 0,
                           directed_rows[r].typed, typed_res);
        end
        drain_pipeline();

        // Random phases: sender gaps at 0, 52, 0 and 24 percent
        typed_res = '0;
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1) ? 52 : (phase == 3) ? 24 : 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                kind = $urandom_range(0, 9);
                num  = $signed($urandom) >>> $urandom_range(0, 31);
                den  = $signed($urandom) >>> $urandom_range(0, 31);
                case (kind) inside
                    // Well-formed fraction: smaller magnitude on top
                    [0:5]: begin
                        mag_n = (num < 0) ? -longint'(num) : longint'(num);
                        mag_d = (den < 0) ? -longint'(den) : longint'(den);
                        if (mag_n > mag_d) begin
                            tmp = num;
                            num = den;
                            den = tmp;
                        end
                    end
                    // Raw full-width operands
                    6: begin
                        num = $urandom;
                        den = $urandom;
                    end
                    // Tiny divisors, zero after halving or not
                    7: den = $signed(32'($urandom_range(0, 4))) - 32'sd2;
                    // Equal magnitudes or zero numerator
                    8: begin
                        case ($urandom_range(0, 2))
                            0:       num = den;
                            1:       num = -den;
                            default: num = '0;
                        endcase
                    end
                    // Range-reduction boundaries
                    default: begin
                        num = edge_vals[$urandom_range(0, 8)];
                        den = edge_vals[$urandom_range(0, 8)];
                    end
                endcase
                issue_division(num, den, idle_pct, 1'b0, typed_res);
            end
            drain_pipeline();
        end

        // Catch any stray result after the last one owed
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("Sent %0d operand pairs, checked %0d quotients: %0d ok (%0d negative),",
                 items_sent, quotients_checked, ok_seen, negative_seen);
        $display("%0d zero divisors, %0d out of range; gaps at 0/52/0/24 percent.",
                 div_zero_seen, range_seen);
        if (error_count == 0 && owed_quotients.size() == 0) begin
            $display("[signed_fraction_to_binary] OK");
        end else begin
            $display("%0d mismatches, %0d quotients still owed",
                     error_count, owed_quotients.size());
            $display("[signed_fraction_to_binary] ERROR");
        end
        $finish;
    end

endmodule

### signed_fraction_to_binary.f
+incdir+rtl
rtl/sfb_pkg.sv
rtl/sfb_prep.sv
rtl/sfb_div_step.sv
rtl/sfb_out.sv
rtl/signed_fraction_to_binary.sv
rtl/sfb_checker.sv
tb/sv/signed_fraction_to_binary_test.sv
